// ----- hw/rtl/dual_bank_palette_ram_argb_assert.svh -----
// ---------------------------------------------------------------------------
// dual_bank_palette_ram_argb assertion macros
// Shorthand for the clocked checks used by the palette ram modules.
// ---------------------------------------------------------------------------
`ifndef DUAL_BANK_PALETTE_RAM_ARGB_ASSERT_SVH
`define DUAL_BANK_PALETTE_RAM_ARGB_ASSERT_SVH

// check that is switched off while reset is high
`define DBPAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that must also hold during reset
`define DBPAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dbpal_pkg.sv -----
// ---------------------------------------------------------------------------
// dbpal_pkg
// Types, codes and colour conversion shared by the dual bank palette ram.
// ---------------------------------------------------------------------------
package dbpal_pkg;

  localparam int PALETTE_COUNT_DEF  = 256;
  localparam int COLORS_PER_PALETTE = 16;
  localparam int BANK_COUNT         = 2;
  localparam int WORD_W             = 16;
  localparam int OFFSET_W           = 13;
  localparam int ARGB_W             = 32;

  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_SELECT = 2'd2;
  localparam logic [1:0] FUNC_LOOKUP = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]          func;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]   write_word;
    logic                new_bank;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] raw_word;
    logic [ARGB_W-1:0] argb_color;
    logic              bank_now;
  } out_word_t;

  // what the result stage needs to know about an item whose read is in flight
  typedef struct packed {
    logic [1:0] func;
    logic       in_range;
    logic       opaque;
    logic       bank;
  } item_tag_t;

  // six bit channel {color, extra, dark} widened to eight bits
  function automatic logic [7:0] widen_channel(input logic [3:0] four,
                                               input logic       extra,
                                               input logic       dark);
    logic [5:0] c6;
    begin
      c6 = {four, extra, dark};
      return {c6, c6[5:4]};
    end
  endfunction

  function automatic logic [ARGB_W-1:0] word_to_argb(input logic [WORD_W-1:0] w);
    begin
      return {ALPHA_OPAQUE,
              widen_channel(w[11:8], w[14], w[15]),
              widen_channel(w[7:4],  w[13], w[15]),
              widen_channel(w[3:0],  w[12], w[15])};
    end
  endfunction

endpackage

// ----- hw/rtl/dbpal_ram.sv -----
// ---------------------------------------------------------------------------
// dbpal_ram
// Generic simple dual port ram: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module dbpal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/dbpal_out.sv -----
// ---------------------------------------------------------------------------
// dbpal_out
// Result stage: formats the ram read word and holds it in the output register.
// ---------------------------------------------------------------------------
`include "dual_bank_palette_ram_argb_assert.svh"

module dbpal_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  input  dbpal_pkg::item_tag_t             s1_tag,
  input  logic [dbpal_pkg::WORD_W-1:0]     rdata,
  output logic                             room,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dbpal_pkg::out_word_t             out_data
);

  dbpal_pkg::out_word_t result;

  assign room = !out_valid || out_ready;

  always_comb begin
    result.raw_word   = '0;
    result.argb_color = '0;
    result.bank_now   = s1_tag.bank;
    if (s1_tag.func == dbpal_pkg::FUNC_READ && s1_tag.in_range) begin
      result.raw_word = rdata;
    end
    if (s1_tag.func == dbpal_pkg::FUNC_LOOKUP && s1_tag.in_range && s1_tag.opaque) begin
      result.argb_color = dbpal_pkg::word_to_argb(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= s1_valid;
    end
    if (room && s1_valid) begin
      out_data <= result;
    end
  end

  `DBPAL_ASSERT(a_s1_moves_out, s1_valid && room |=> out_valid, "pending word not moved out")

endmodule

// ----- hw/rtl/dual_bank_palette_ram_argb.sv -----
// ---------------------------------------------------------------------------
// dual_bank_palette_ram_argb
// Two banks of 16-bit palette words with raw access and ARGB8888 lookup.
//
//   channel  signals                      word
//   in       in_valid / in_ready          in_data  (func, offset, write_word, new_bank)
//   out      out_valid / out_ready        out_data (raw_word, argb_color, bank_now)
//
// One word per cycle while the output is not stalled; each word passes the
// ram read register, then the output register.
// After reset a clearing pass zeroes all BANK_COUNT * PALETTE_COUNT * 16
// entries (8192 by default), one entry a cycle, in_ready low.
// Writes and bank selects take effect at acceptance, so the next word sees them.
// A stalled output holds the result stage and then the input.
// ---------------------------------------------------------------------------
`include "dual_bank_palette_ram_argb_assert.svh"

module dual_bank_palette_ram_argb #(
  parameter int PALETTE_COUNT = dbpal_pkg::PALETTE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dbpal_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dbpal_pkg::out_word_t out_data
);

  localparam int ENTRIES = PALETTE_COUNT * dbpal_pkg::COLORS_PER_PALETTE;
  localparam int DEPTH   = dbpal_pkg::BANK_COUNT * ENTRIES;
  localparam int AW      = $clog2(DEPTH);

  logic                           clearing;
  logic [AW-1:0]                  clr_addr;
  logic                           active_bank;
  logic                           s1_valid;
  dbpal_pkg::item_tag_t           s1_tag;
  logic                           room;
  logic                           acc;
  logic                           in_range;
  logic                           bank_after;
  logic [AW-1:0]                  item_addr;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [dbpal_pkg::WORD_W-1:0]   ram_wdata;
  logic [dbpal_pkg::WORD_W-1:0]   ram_rdata;

  assign in_ready = !clearing && (!s1_valid || room);
  assign acc      = in_valid && in_ready;
  assign in_range = in_data.offset < dbpal_pkg::OFFSET_W'(ENTRIES);

  assign bank_after = (in_data.func == dbpal_pkg::FUNC_SELECT) ? in_data.new_bank
                                                               : active_bank;

  // bank 1 sits above bank 0 in the shared ram
  assign item_addr = active_bank ? AW'(in_data.offset) + AW'(ENTRIES)
                                 : AW'(in_data.offset);

  assign ram_we    = clearing || (acc && in_data.func == dbpal_pkg::FUNC_WRITE && in_range);
  assign ram_waddr = clearing ? clr_addr : item_addr;
  assign ram_wdata = clearing ? '0 : in_data.write_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clr_addr    <= '0;
      active_bank <= 1'b0;
      s1_valid    <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (acc && in_data.func == dbpal_pkg::FUNC_SELECT) begin
        active_bank <= in_data.new_bank;
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (room) begin
        s1_valid <= 1'b0;
      end
    end
    if (acc) begin
      s1_tag.func     <= in_data.func;
      s1_tag.in_range <= in_range;
      s1_tag.opaque   <= in_data.offset[3:0] != 4'd0;
      s1_tag.bank     <= bank_after;
    end
  end

  dbpal_ram #(
    .WIDTH (dbpal_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (item_addr),
    .rdata (ram_rdata)
  );

  dbpal_out u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_tag    (s1_tag),
    .rdata     (ram_rdata),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `DBPAL_ASSERT_ALWAYS(a_clear_blocks_input, clearing |-> !in_ready, "input open during clear")
  `DBPAL_ASSERT(a_s1_holds, s1_valid && !room |=> s1_valid && $stable(s1_tag), "stage lost word")
  `DBPAL_ASSERT(a_bank_only_on_select, !(acc && in_data.func == dbpal_pkg::FUNC_SELECT) |=> $stable(active_bank), "bank moved without select")

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual bank palette ram. Drives raw reads,
// writes, bank selects and colour lookups through the valid/ready input,
// keeps a shadow copy of both banks and the active bank, and compares every
// output word field by field against a typed row's word or the shadow's prediction.
// A directed table covers reset contents, range edges, transparent entries and bank
// switching. A long random run follows under several idle and stall mixes.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int ENTRIES_PER_BANK = dbpal_pkg::PALETTE_COUNT_DEF *
                                    dbpal_pkg::COLORS_PER_PALETTE;
  localparam int TOTAL_ENTRIES    = dbpal_pkg::BANK_COUNT * ENTRIES_PER_BANK;
  localparam int RANDOM_WORDS     = 1500;
  localparam int PHASE_WORDS      = 250;
  localparam int DRAIN_CYCLES     = 16;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PRINT_LIMIT      = 100;

  typedef struct {
    dbpal_pkg::in_word_t  stim;
    bit                   typed;
    dbpal_pkg::out_word_t want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  dbpal_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dbpal_pkg::out_word_t out_data;

  // shadow state of the block
  logic [dbpal_pkg::WORD_W-1:0] shadow_ram [0:TOTAL_ENTRIES-1];
  logic                         shadow_bank;

  dbpal_pkg::out_word_t pending_results [$];
  stim_row_t            directed_rows [$];
  int                   error_count = 0;
  int                   results_seen = 0;
  int                   cycle_count = 0;
  int                   sender_idle_pct = 0;
  int                   recv_stall_pct = 0;

  dual_bank_palette_ram_argb DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // six bit channel stretched to eight by repeating its top bits
  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, 2'b00} | {6'b000000, v[5:4]};
  endfunction

  function automatic logic [dbpal_pkg::ARGB_W-1:0] expected_argb(
      input logic [dbpal_pkg::WORD_W-1:0] w);
    return {dbpal_pkg::ALPHA_OPAQUE,
            widen6({w[11:8], w[14], w[15]}),
            widen6({w[7:4], w[13], w[15]}),
            widen6({w[3:0], w[12], w[15]})};
  endfunction

  function automatic dbpal_pkg::out_word_t predict_palette_result(
      input dbpal_pkg::in_word_t w);
    dbpal_pkg::out_word_t res;
    logic [dbpal_pkg::OFFSET_W-1:0] idx;
    bit in_range;
    res = '0;
    in_range = w.offset < dbpal_pkg::OFFSET_W'(ENTRIES_PER_BANK);
    idx = {shadow_bank, w.offset[11:0]};
    case (w.func)
      dbpal_pkg::FUNC_READ: if (in_range) res.raw_word = shadow_ram[idx];
      dbpal_pkg::FUNC_WRITE: if (in_range) shadow_ram[idx] = w.write_word;
      dbpal_pkg::FUNC_SELECT: shadow_bank = w.new_bank;
      default: begin
        if (in_range && w.offset[3:0] != 4'd0) begin
          res.argb_color = expected_argb(shadow_ram[idx]);
        end
      end
    endcase
    res.bank_now = shadow_bank;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
  endtask

  task automatic add_row(input logic [1:0] f, input logic [dbpal_pkg::OFFSET_W-1:0] off,
                         input logic [dbpal_pkg::WORD_W-1:0] wd, input logic nb,
                         input bit typed, input logic [dbpal_pkg::WORD_W-1:0] raw,
                         input logic [dbpal_pkg::ARGB_W-1:0] argb, input logic bank);
    stim_row_t row;
    row.stim = '{func: f, offset: off, write_word: wd, new_bank: nb};
    row.typed = typed;
    row.want = '{raw_word: raw, argb_color: argb, bank_now: bank};
    directed_rows.push_back(row);
  endtask

  // holds the word until accepted; idle gaps only come before valid rises
  task automatic send_word(input dbpal_pkg::in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (recv_stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    dbpal_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected", out_data.argb_color, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.raw_word !== want.raw_word)
          report_mismatch("raw_word", 32'(out_data.raw_word), 32'(want.raw_word));
        if (out_data.argb_color !== want.argb_color)
          report_mismatch("argb_color", out_data.argb_color, want.argb_color);
        if (out_data.bank_now !== want.bank_now)
          report_mismatch("bank_now", 32'(out_data.bank_now), 32'(want.bank_now));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_results.size());
      $display("** dual_bank_palette_ram_argb: FAILED **");
      $finish;
    end
  end

  initial begin
    dbpal_pkg::in_word_t  stim;
    dbpal_pkg::out_word_t pred;
    stim_row_t row;
    logic [7:0] hot_page [4];
    int r;
    int sel;
    shadow_ram = '{default: '0};
    shadow_bank = 1'b0;

    // func, offset, write_word, new_bank, typed, raw, argb, bank
    add_row(dbpal_pkg::FUNC_READ,   13'd0,    16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd1,    16'hFFFF, 1'b1, 1'b1, 16'h0000, 32'hFF00_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd0,    16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_WRITE,  13'd1,    16'hFFFF, 1'b1, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd1,    16'h0000, 1'b0, 1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    add_row(dbpal_pkg::FUNC_READ,   13'd1,    16'h0000, 1'b1, 1'b1, 16'hFFFF, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_WRITE,  13'd4095, 16'h8000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd4095, 16'h0000, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(dbpal_pkg::FUNC_READ,   13'd4095, 16'hFFFF, 1'b0, 1'b0, '0, '0, 1'b0);
    // out of range: write dropped, read and lookup give zero
    add_row(dbpal_pkg::FUNC_WRITE,  13'd4096, 16'h1234, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_READ,   13'd4096, 16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd8191, 16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    // transparent entry stores its word but looks up as zero
    add_row(dbpal_pkg::FUNC_WRITE,  13'd16,   16'h7ABC, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd16,   16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_READ,   13'd16,   16'h0000, 1'b0, 1'b0, '0, '0, 1'b0);
    // other bank starts out empty
    add_row(dbpal_pkg::FUNC_SELECT, 13'd1,    16'hFFFF, 1'b1, 1'b1, 16'h0000, 32'h0000_0000, 1'b1);
    add_row(dbpal_pkg::FUNC_READ,   13'd1,    16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b1);
    add_row(dbpal_pkg::FUNC_WRITE,  13'd1,    16'h4321, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b1);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd1,    16'h0000, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(dbpal_pkg::FUNC_SELECT, 13'd0,    16'h0000, 1'b1, 1'b1, 16'h0000, 32'h0000_0000, 1'b1);
    add_row(dbpal_pkg::FUNC_SELECT, 13'd0,    16'h0000, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_READ,   13'd1,    16'h0000, 1'b1, 1'b1, 16'hFFFF, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_WRITE,  13'd17,   16'h7000, 1'b1, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);
    add_row(dbpal_pkg::FUNC_LOOKUP, 13'd17,   16'hFFFF, 1'b1, 1'b0, '0, '0, 1'b0);
    add_row(dbpal_pkg::FUNC_SELECT, 13'd8191, 16'hFFFF, 1'b0, 1'b1, 16'h0000, 32'h0000_0000, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // in_ready stays low through the clearing pass
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.stim);
      pred = predict_palette_result(row.stim);
      pending_results.push_back(row.typed ? row.want : pred);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        case ((n / PHASE_WORDS) % 4)
          0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
          2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
          default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
        endcase
        // a few busy palettes so reads and lookups hit written entries
        foreach (hot_page[k]) hot_page[k] = 8'($urandom_range(255));
      end
      r = $urandom_range(99);
      if (r < 25) stim.func = dbpal_pkg::FUNC_READ;
      else if (r < 55) stim.func = dbpal_pkg::FUNC_WRITE;
      else if (r < 65) stim.func = dbpal_pkg::FUNC_SELECT;
      else stim.func = dbpal_pkg::FUNC_LOOKUP;
      sel = $urandom_range(99);
      if (sel < 65)
        stim.offset = {1'b0, hot_page[2'($urandom_range(3))], 4'($urandom_range(15))};
      else if (sel < 85) stim.offset = 13'($urandom_range(ENTRIES_PER_BANK - 1));
      else stim.offset = 13'($urandom_range(8191, ENTRIES_PER_BANK));
      stim.write_word = 16'($urandom_range(65535));
      stim.new_bank = 1'($urandom_range(1));
      send_word(stim);
      pending_results.push_back(predict_palette_result(stim));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** dual_bank_palette_ram_argb: PASSED **");
    end else begin
      $display("%0d mismatches", error_count);
      $display("** dual_bank_palette_ram_argb: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dbpal_pkg.sv
hw/rtl/dbpal_ram.sv
hw/rtl/dbpal_out.sv
hw/rtl/dual_bank_palette_ram_argb.sv
bench/tb_top.sv
